// File: rtl/core/qlt_pkg.sv
// Shared types, constants and helper functions for the query-language tokenizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package qlt_pkg;

  localparam int POSITION_BITS = 32;
  localparam int COUNTER_BITS  = 16;
  localparam int KW_DEPTH      = 6;
  localparam int KW_IDX_W      = $clog2(KW_DEPTH);
  localparam int KW_NUM        = 15;
  localparam int MAX_RES       = 4;
  localparam int RES_CNT_W     = $clog2(MAX_RES + 1);
  localparam int SLOT_W        = $clog2(MAX_RES);
  localparam int FIFO_DEPTH    = 4;
  localparam int FPTR_W        = $clog2(FIFO_DEPTH);
  localparam int FCNT_W        = $clog2(FIFO_DEPTH + 2);

  localparam int START_W = 32;
  localparam int FIELD_W = 16;

  typedef logic [7:0]                 byte_t;
  typedef logic [POSITION_BITS-1:0]   pos_t;
  typedef logic [COUNTER_BITS-1:0]    cnt_t;
  typedef logic [5:0]                 kind_t;
  typedef logic [1:0]                 err_t;
  typedef logic [KW_DEPTH-1:0][7:0]   kwbuf_t;
  typedef logic [FPTR_W-1:0]          fptr_t;
  typedef logic [FCNT_W-1:0]          fcnt_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [RES_CNT_W-1:0]       rcnt_t;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_BANG  = 4'd1,
    M_GT    = 4'd2,
    M_LT    = 4'd3,
    M_DASH  = 4'd4,
    M_STR   = 4'd5,
    M_INT   = 4'd6,
    M_FRAC  = 4'd7,
    M_IDENT = 4'd8
  } mode_t;

  // Token kinds
  localparam kind_t K_LPAR   = 6'd0;
  localparam kind_t K_RPAR   = 6'd1;
  localparam kind_t K_LBRK   = 6'd2;
  localparam kind_t K_RBRK   = 6'd3;
  localparam kind_t K_LBRC   = 6'd4;
  localparam kind_t K_RBRC   = 6'd5;
  localparam kind_t K_COMMA  = 6'd6;
  localparam kind_t K_DOT    = 6'd7;
  localparam kind_t K_SEMI   = 6'd8;
  localparam kind_t K_COLON  = 6'd9;
  localparam kind_t K_NE     = 6'd10;
  localparam kind_t K_EQ     = 6'd11;
  localparam kind_t K_GE     = 6'd12;
  localparam kind_t K_GT     = 6'd13;
  localparam kind_t K_LARROW = 6'd14;
  localparam kind_t K_LE     = 6'd15;
  localparam kind_t K_LT     = 6'd16;
  localparam kind_t K_RARROW = 6'd17;
  localparam kind_t K_MINUS  = 6'd18;
  localparam kind_t K_STRING = 6'd19;
  localparam kind_t K_NUMBER = 6'd20;
  localparam kind_t K_IDENT  = 6'd21;
  localparam kind_t K_KW0    = 6'd22;
  localparam kind_t K_END    = 6'd37;

  // Error codes
  localparam err_t E_NONE   = 2'd0;
  localparam err_t E_BANG   = 2'd1;
  localparam err_t E_UNEXP  = 2'd2;
  localparam err_t E_UNTERM = 2'd3;

  // Source characters
  localparam byte_t CH_LPAR  = 8'h28;
  localparam byte_t CH_RPAR  = 8'h29;
  localparam byte_t CH_LBRK  = 8'h5B;
  localparam byte_t CH_RBRK  = 8'h5D;
  localparam byte_t CH_LBRC  = 8'h7B;
  localparam byte_t CH_RBRC  = 8'h7D;
  localparam byte_t CH_COMMA = 8'h2C;
  localparam byte_t CH_DOT   = 8'h2E;
  localparam byte_t CH_SEMI  = 8'h3B;
  localparam byte_t CH_COLON = 8'h3A;
  localparam byte_t CH_EQ    = 8'h3D;
  localparam byte_t CH_BANG  = 8'h21;
  localparam byte_t CH_GT    = 8'h3E;
  localparam byte_t CH_LT    = 8'h3C;
  localparam byte_t CH_DASH  = 8'h2D;
  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_SP    = 8'h20;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_NL    = 8'h0A;
  localparam byte_t CH_UNDER = 8'h5F;
  localparam byte_t CH_0     = 8'h30;
  localparam byte_t CH_9     = 8'h39;
  localparam byte_t CH_UA    = 8'h41;
  localparam byte_t CH_UZ    = 8'h5A;
  localparam byte_t CH_LA    = 8'h61;
  localparam byte_t CH_LZ    = 8'h7A;

  // Keyword text, right-justified: the first character sits in the top used byte.
  localparam logic [8*KW_DEPTH-1:0] KW_TEXT [KW_NUM] = '{
    "MATCH", "WHERE", "RETURN", "DELETE", "SET", "CREATE", "ORDER", "BY",
    "LIMIT", "AND", "OR", "ASC", "DESC", "true", "false"
  };
  localparam logic [KW_IDX_W-1:0] KW_LEN [KW_NUM] = '{
    3'd5, 3'd5, 3'd6, 3'd6, 3'd3, 3'd6, 3'd5, 3'd2,
    3'd5, 3'd3, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5
  };

  typedef struct packed {
    mode_t  mode;
    logic   pend_dot;
    pos_t   pos;
    pos_t   tstart;
    cnt_t   line;
    cnt_t   col;
    cnt_t   tcol;
    kwbuf_t kwbuf;
    logic   err_lock;
  } state_t;

  localparam state_t ST_RESET = '{
    mode:     M_IDLE,
    pend_dot: 1'b0,
    pos:      '0,
    tstart:   '0,
    line:     cnt_t'(1),
    col:      cnt_t'(1),
    tcol:     cnt_t'(1),
    kwbuf:    '0,
    err_lock: 1'b0
  };

  typedef struct packed {
    kind_t              kind;
    err_t               err;
    logic [START_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] col;
    logic               last;
  } result_t;

  // All results caused by one source word.
  typedef struct packed {
    rcnt_t                  n;
    result_t [MAX_RES-1:0]  res;
  } batch_t;

  typedef struct packed {
    fcnt_t cnt;
  } fifo_stat_t;

  localparam pos_t CNT_MAX_POS = pos_t'({COUNTER_BITS{1'b1}});

  function automatic pos_t pos_inc(input pos_t v);
    return (&v) ? v : v + pos_t'(1);
  endfunction

  function automatic cnt_t cnt_inc(input cnt_t v);
    return (&v) ? v : v + cnt_t'(1);
  endfunction

  function automatic pos_t pos_dec(input pos_t v);
    return (v == '0) ? v : v - pos_t'(1);
  endfunction

  function automatic cnt_t cnt_dec(input cnt_t v);
    return (v == '0) ? v : v - cnt_t'(1);
  endfunction

  // Saturating distance from the token start to a given end position.
  function automatic cnt_t span(input pos_t end_pos, input pos_t start_pos);
    pos_t d;
    d = (end_pos >= start_pos) ? end_pos - start_pos : '0;
    return (d > CNT_MAX_POS) ? '1 : cnt_t'(d);
  endfunction

  function automatic logic is_digit(input byte_t c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha(input byte_t c);
    return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

  function automatic result_t mk_res(input kind_t kind, input err_t err, input pos_t start,
                                     input cnt_t len, input cnt_t line, input cnt_t col,
                                     input logic last);
    result_t r;
    r.kind  = kind;
    r.err   = err;
    r.start = START_W'(start);
    r.len   = FIELD_W'(len);
    r.line  = FIELD_W'(line);
    r.col   = FIELD_W'(col);
    r.last  = last;
    return r;
  endfunction

  function automatic result_t tok(input kind_t kind, input state_t s, input pos_t end_pos);
    return mk_res(kind, E_NONE, s.tstart, span(end_pos, s.tstart), s.line, s.tcol, 1'b0);
  endfunction

  function automatic batch_t add(input batch_t b, input result_t r);
    batch_t o;
    o = b;
    if (b.n < rcnt_t'(MAX_RES)) begin
      o.res[SLOT_W'(b.n)] = r;
      o.n = b.n + rcnt_t'(1);
    end
    return o;
  endfunction

  function automatic state_t step_pos(input state_t s);
    state_t o;
    o = s;
    o.pos = pos_inc(s.pos);
    o.col = cnt_inc(s.col);
    return o;
  endfunction

  // Keyword lookup: exact length and text match, otherwise a plain identifier.
  function automatic kind_t kw_kind(input kwbuf_t kw, input cnt_t len);
    kind_t k;
    logic  hit;
    logic  found;
    int    n;
    int    idx;
    k     = K_IDENT;
    found = 1'b0;
    for (int w = 0; w < KW_NUM; w++) begin
      n   = int'(KW_LEN[w]);
      hit = (len == cnt_t'(KW_LEN[w]));
      for (int i = 0; i < KW_DEPTH; i++) begin
        idx = (i < n) ? (n - 1 - i) : 0;
        if ((i < n) && (kw[i] != KW_TEXT[w][idx*8 +: 8])) hit = 1'b0;
      end
      if (hit && !found) begin
        k     = kind_t'(K_KW0 + kind_t'(w));
        found = 1'b1;
      end
    end
    return k;
  endfunction

endpackage

// File: rtl/core/qlt_if.sv
// Word channel interfaces of the query-language tokenizer: source bytes in, tokens out.
// Depends on qlt_pkg for the field widths.
`timescale 1ns / 1ps

interface qlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       is_last;

  modport source (output valid, output ch, output has_char, output is_last, input ready);
  modport sink   (input valid, input ch, input has_char, input is_last, output ready);
endinterface

interface qlt_out_if;
  import qlt_pkg::*;
  logic               valid;
  logic               ready;
  kind_t              token_kind;
  err_t               error_code;
  logic [START_W-1:0] start_offset;
  logic [FIELD_W-1:0] token_length;
  logic [FIELD_W-1:0] line_number;
  logic [FIELD_W-1:0] column_number;
  logic               last_of_run;

  modport source (output valid, output token_kind, output error_code, output start_offset,
                  output token_length, output line_number, output column_number,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input error_code, input start_offset,
                  input token_length, input line_number, input column_number,
                  input last_of_run, output ready);
endinterface

// File: rtl/core/qlt_step.sv
// One scanning step: next scanner state and up to four results for one source word.
// Depends on qlt_pkg.
`timescale 1ns / 1ps

module qlt_step import qlt_pkg::*; (
  input  state_t st,
  input  byte_t  ch,
  input  logic   has_char,
  input  logic   is_last,
  output state_t st_nxt,
  output batch_t batch
);

  state_t s;
  batch_t b;
  logic   rescan;
  logic   single_v;
  kind_t  single_k;
  logic   other;
  cnt_t   n;
  pos_t   dot_pos;

  always_comb begin
    s        = st;
    b        = '0;
    rescan   = 1'b0;
    single_v = 1'b0;
    single_k = K_LPAR;
    other    = 1'b0;
    n        = span(st.pos, st.tstart);
    dot_pos  = pos_dec(st.pos);

    if (has_char && !s.err_lock) begin
      unique case (s.mode)
        M_BANG: begin
          if (ch == CH_EQ) begin
            b      = add(b, tok(K_NE, s, pos_inc(s.pos)));
            s.mode = M_IDLE;
            s      = step_pos(s);
          end else begin
            b          = add(b, mk_res(K_LPAR, E_BANG, s.tstart, cnt_t'(1), s.line, s.col,
                                       1'b1));
            s.err_lock = 1'b1;
          end
        end
        M_GT: begin
          if (ch == CH_EQ) begin
            b      = add(b, tok(K_GE, s, pos_inc(s.pos)));
            s.mode = M_IDLE;
            s      = step_pos(s);
          end else begin
            b      = add(b, tok(K_GT, s, s.pos));
            rescan = 1'b1;
          end
        end
        M_LT: begin
          if (ch == CH_DASH) begin
            b      = add(b, tok(K_LARROW, s, pos_inc(s.pos)));
            s.mode = M_IDLE;
            s      = step_pos(s);
          end else if (ch == CH_EQ) begin
            b      = add(b, tok(K_LE, s, pos_inc(s.pos)));
            s.mode = M_IDLE;
            s      = step_pos(s);
          end else begin
            b      = add(b, tok(K_LT, s, s.pos));
            rescan = 1'b1;
          end
        end
        M_DASH: begin
          if (ch == CH_GT) begin
            b      = add(b, tok(K_RARROW, s, pos_inc(s.pos)));
            s.mode = M_IDLE;
            s      = step_pos(s);
          end else begin
            b      = add(b, tok(K_MINUS, s, s.pos));
            rescan = 1'b1;
          end
        end
        M_STR: begin
          if (ch == CH_QUOTE) begin
            s      = step_pos(s);
            b      = add(b, tok(K_STRING, s, s.pos));
            s.mode = M_IDLE;
          end else begin
            // A newline inside a string restarts the column, which the step below
            // then advances past the newline itself.
            if (ch == CH_NL) begin
              s.line = cnt_inc(s.line);
              s.col  = cnt_t'(1);
            end
            s = step_pos(s);
          end
        end
        M_INT: begin
          if (s.pend_dot) begin
            if (is_digit(ch)) begin
              s.pend_dot = 1'b0;
              s.mode     = M_FRAC;
              s          = step_pos(s);
            end else begin
              // The dot did not start a fraction: number, then the dot on its own.
              b          = add(b, tok(K_NUMBER, s, dot_pos));
              b          = add(b, mk_res(K_DOT, E_NONE, dot_pos, cnt_t'(1), s.line,
                                         cnt_dec(s.col), 1'b0));
              s.pend_dot = 1'b0;
              rescan     = 1'b1;
            end
          end else if (is_digit(ch)) begin
            s = step_pos(s);
          end else if (ch == CH_DOT) begin
            s.pend_dot = 1'b1;
            s          = step_pos(s);
          end else begin
            b      = add(b, tok(K_NUMBER, s, s.pos));
            rescan = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(ch)) begin
            s = step_pos(s);
          end else begin
            b      = add(b, tok(K_NUMBER, s, s.pos));
            rescan = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(ch) || is_digit(ch) || (ch == CH_UNDER)) begin
            if (n < cnt_t'(KW_DEPTH)) s.kwbuf[KW_IDX_W'(n)] = ch;
            s = step_pos(s);
          end else begin
            b      = add(b, tok(kw_kind(s.kwbuf, n), s, s.pos));
            rescan = 1'b1;
          end
        end
        default: begin
          rescan = 1'b1;
        end
      endcase

      if (rescan) begin
        s.mode   = M_IDLE;
        s.tstart = s.pos;
        s.tcol   = s.col;
        unique case (ch) inside
          CH_LPAR:  begin single_v = 1'b1; single_k = K_LPAR;  end
          CH_RPAR:  begin single_v = 1'b1; single_k = K_RPAR;  end
          CH_LBRK:  begin single_v = 1'b1; single_k = K_LBRK;  end
          CH_RBRK:  begin single_v = 1'b1; single_k = K_RBRK;  end
          CH_LBRC:  begin single_v = 1'b1; single_k = K_LBRC;  end
          CH_RBRC:  begin single_v = 1'b1; single_k = K_RBRC;  end
          CH_COMMA: begin single_v = 1'b1; single_k = K_COMMA; end
          CH_DOT:   begin single_v = 1'b1; single_k = K_DOT;   end
          CH_SEMI:  begin single_v = 1'b1; single_k = K_SEMI;  end
          CH_COLON: begin single_v = 1'b1; single_k = K_COLON; end
          CH_EQ:    begin single_v = 1'b1; single_k = K_EQ;    end
          CH_BANG:  begin s.mode = M_BANG; s = step_pos(s); end
          CH_GT:    begin s.mode = M_GT;   s = step_pos(s); end
          CH_LT:    begin s.mode = M_LT;   s = step_pos(s); end
          CH_DASH:  begin s.mode = M_DASH; s = step_pos(s); end
          CH_QUOTE: begin s.mode = M_STR;  s = step_pos(s); end
          CH_SP, CH_CR, CH_TAB: begin
            s = step_pos(s);
          end
          CH_NL: begin
            s.pos  = pos_inc(s.pos);
            s.line = cnt_inc(s.line);
            s.col  = cnt_t'(1);
          end
          default: begin
            other = 1'b1;
          end
        endcase

        if (single_v) begin
          b = add(b, tok(single_k, s, pos_inc(s.pos)));
          s = step_pos(s);
        end else if (other) begin
          if (is_digit(ch)) begin
            s.mode     = M_INT;
            s.pend_dot = 1'b0;
            s          = step_pos(s);
          end else if (is_alpha(ch) || (ch == CH_UNDER)) begin
            s.kwbuf    = '0;
            s.kwbuf[0] = ch;
            s.mode     = M_IDENT;
            s          = step_pos(s);
          end else begin
            b          = add(b, mk_res(K_LPAR, E_UNEXP, s.tstart, cnt_t'(1), s.line,
                                       cnt_inc(s.col), 1'b1));
            s.err_lock = 1'b1;
          end
        end
      end
    end

    if (is_last) begin
      if (!s.err_lock) begin
        unique case (s.mode)
          M_BANG: begin
            b          = add(b, mk_res(K_LPAR, E_BANG, s.tstart, cnt_t'(1), s.line, s.col,
                                       1'b1));
            s.err_lock = 1'b1;
          end
          M_STR: begin
            b          = add(b, mk_res(K_LPAR, E_UNTERM, s.tstart, span(s.pos, s.tstart),
                                       s.line, s.col, 1'b1));
            s.err_lock = 1'b1;
          end
          M_GT:   b = add(b, tok(K_GT, s, s.pos));
          M_LT:   b = add(b, tok(K_LT, s, s.pos));
          M_DASH: b = add(b, tok(K_MINUS, s, s.pos));
          M_INT: begin
            if (s.pend_dot) begin
              b = add(b, tok(K_NUMBER, s, pos_dec(s.pos)));
              b = add(b, mk_res(K_DOT, E_NONE, pos_dec(s.pos), cnt_t'(1), s.line,
                                cnt_dec(s.col), 1'b0));
            end else begin
              b = add(b, tok(K_NUMBER, s, s.pos));
            end
          end
          M_FRAC:  b = add(b, tok(K_NUMBER, s, s.pos));
          M_IDENT: b = add(b, tok(kw_kind(s.kwbuf, span(s.pos, s.tstart)), s, s.pos));
          default: begin
          end
        endcase
        if (!s.err_lock) begin
          b = add(b, mk_res(K_END, E_NONE, s.pos, '0, s.line, s.col, 1'b1));
        end
      end
      s = ST_RESET;
    end

    st_nxt = s;
    batch  = b;
  end

endmodule

// File: rtl/core/qlt_res_fifo.sv
// Result queue: holds the batches of results per source word and hands them out one
// at a time. Depends on qlt_pkg.
`timescale 1ns / 1ps

module qlt_res_fifo import qlt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  batch_t     push_batch,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res,
  output fifo_stat_t stat
);

  batch_t mem_r [FIFO_DEPTH];
  fptr_t  wr_ptr_r;
  fptr_t  rd_ptr_r;
  fcnt_t  cnt_r;
  fcnt_t  cnt_nxt;
  slot_t  slot_r;
  logic   pop_slot;
  logic   pop_entry;

  assign res_valid = (cnt_r != '0);
  assign res       = mem_r[rd_ptr_r].res[slot_r];
  assign pop_slot  = res_valid && res_ready;
  assign pop_entry = pop_slot &&
                     ((rcnt_t'(slot_r) + rcnt_t'(1)) == mem_r[rd_ptr_r].n);
  assign cnt_nxt   = cnt_r + fcnt_t'(push) - fcnt_t'(pop_entry);
  assign stat.cnt  = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_batch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      slot_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + fptr_t'(1);
      end
      if (pop_entry) begin
        rd_ptr_r <= rd_ptr_r + fptr_t'(1);
        slot_r   <= '0;
      end else if (pop_slot) begin
        slot_r <= slot_r + slot_t'(1);
      end
    end
  end

endmodule

// File: rtl/core/query_language_tokenizer_top.sv
// Top level of the streaming query-language tokenizer.
// Depends on qlt_pkg, qlt_if, qlt_step and qlt_res_fifo.
`timescale 1ns / 1ps

// The tokenizer takes one source byte per word on in_chan and returns tokens on
// out_chan: kind, byte offset, length, line and column, with a coded error result or a
// final END token closing each source. It accepts one word every clock cycle while
// the result queue has room. A word is first captured in an input register; in the
// next cycle a single pass of scanning logic updates the scanner state and writes all
// the results that the word causes (up to four) as one entry into a four-entry result
// queue. Results leave the queue one per cycle while the receiver is ready, so a word
// that yields several results holds the output until each has been taken, and the
// input stays ready as long as the queue can take the word in flight and one more;
// with at most one result per word and a ready receiver the block sustains one byte
// per cycle. There are no configuration registers and no clearing pass after reset.

module query_language_tokenizer_top import qlt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  qlt_in_if.sink    in_chan,
  qlt_out_if.source out_chan
);

  // Input register stage.
  logic       stg_vld_r;
  byte_t      stg_ch_r;
  logic       stg_has_r;
  logic       stg_last_r;

  // Scanner state.
  state_t     st_r;
  state_t     st_nxt;

  batch_t     batch;
  logic       push;
  fifo_stat_t fifo_stat;
  result_t    res;
  logic       in_acc;

  // Space is reserved for the word already in the input register before a new one is
  // taken, so the scanning pass never has to stall.
  assign in_chan.ready = (fifo_stat.cnt + fcnt_t'(stg_vld_r)) < fcnt_t'(FIFO_DEPTH);
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_ch_r   <= in_chan.ch;
      stg_has_r  <= in_chan.has_char;
      stg_last_r <= in_chan.is_last;
    end
  end

  qlt_step u_step (
    .st       (st_r),
    .ch       (stg_ch_r),
    .has_char (stg_has_r),
    .is_last  (stg_last_r),
    .st_nxt   (st_nxt),
    .batch    (batch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (stg_vld_r) begin
      st_r <= st_nxt;
    end
  end

  // Words that cause no result, such as blanks, never enter the queue.
  assign push = stg_vld_r && (batch.n != '0);

  qlt_res_fifo u_res_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_batch (batch),
    .res_valid  (out_chan.valid),
    .res_ready  (out_chan.ready),
    .res        (res),
    .stat       (fifo_stat)
  );

  assign out_chan.token_kind    = res.kind;
  assign out_chan.error_code    = res.err;
  assign out_chan.start_offset  = res.start;
  assign out_chan.token_length  = res.len;
  assign out_chan.line_number   = res.line;
  assign out_chan.column_number = res.col;
  assign out_chan.last_of_run   = res.last;

  // An accepted word is always scanned in the following cycle.
  a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> stg_vld_r)
    else $error("accepted word did not reach the scanning stage");

  // The reservation in the ready term must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_stat.cnt < fcnt_t'(FIFO_DEPTH)))
    else $error("result queue written while full");

  // Every error result closes the run.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.error_code != E_NONE)) |-> out_chan.last_of_run)
    else $error("error result without last_of_run");

  // The end of a source leaves the scanner idle and unlocked.
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r && stg_last_r) |=> ((st_r.mode == M_IDLE) && !st_r.err_lock))
    else $error("scanner not back to idle after end of source");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the streaming query-language tokenizer.
// Depends on qlt_pkg, qlt_if and the RTL under rtl/core; needs no other file.
`timescale 1ns / 1ps

module tb;
  import qlt_pkg::*;

  // Run-length constants. The limit is far above the slowest legal run: some 430 words,
  // each of which may wait for the longest sender gap and then four tokens behind the
  // longest receiver stalls, plus the long hold-off.
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_WORDS = 395;
  localparam int HOLD_CYCLES  = 120;
  localparam int BURST_WORDS  = 48;
  localparam int DRAIN_CYCLES = 24;
  localparam int N_DIRECTED   = 25;

  // Error results carry kind zero, which shares its code with an opening parenthesis.
  localparam kind_t ERROR_KIND = K_LPAR;
  localparam pos_t  CNT_CEIL   = pos_t'({COUNTER_BITS{1'b1}});

  typedef struct packed {
    byte_t ch;
    logic  has_char;
    logic  is_last;
  } src_word_t;

  // One row of the directed part. Where typed is set, the row carries its own expected
  // outcome (nothing, or the single token given); otherwise the scanner model decides.
  typedef struct packed {
    byte_t   ch;
    logic    has_char;
    logic    is_last;
    logic    typed;
    logic    one_token;
    result_t token;
  } stim_row_t;

  localparam result_t NO_TOKEN = '0;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // Empty source straight after reset: only END, at offset 0, line 1, column 1.
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, '{K_END, E_NONE, 32'd0, 16'd0, 16'd1, 16'd1, 1'b1}},
    // A word with neither a byte nor an end mark does nothing.
    '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, NO_TOKEN},
    // A bang followed by anything but an equals sign.
    '{CH_BANG, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{"x", 1'b1, 1'b0, 1'b1, 1'b1, '{ERROR_KIND, E_BANG, 32'd0, 16'd1, 16'd1, 16'd2, 1'b1}},
    // Locked after the error: bytes vanish and the closing word yields no END.
    '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0, NO_TOKEN},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, NO_TOKEN},
    // A byte of 128 or more is unexpected; the column reported is one past it.
    '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, '{ERROR_KIND, E_UNEXP, 32'd0, 16'd1, 16'd1, 16'd2, 1'b1}},
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NO_TOKEN},
    // A string that crosses a newline and is never closed.
    '{CH_QUOTE, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{"a", 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{CH_NL, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{"b", 1'b1, 1'b1, 1'b1, 1'b1, '{ERROR_KIND, E_UNTERM, 32'd0, 16'd4, 16'd2, 16'd3, 1'b1}},
    // Number, dot, letter: the number is split from its dot.
    '{"1", 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{CH_DOT, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{"a", 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    // Two-character operators (<-, ->, >= and !=), then a newline outside any string.
    '{CH_LT, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{CH_DASH, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{CH_DASH, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{CH_GT, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{CH_GT, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{CH_EQ, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{CH_BANG, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{CH_EQ, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    '{CH_NL, 1'b1, 1'b0, 1'b0, 1'b0, NO_TOKEN},
    // A pending less-than closed by the end of the source, then END.
    '{CH_LT, 1'b1, 1'b1, 1'b0, 1'b0, NO_TOKEN}
  };

  string kw_spelling [KW_NUM] = '{
    "MATCH", "WHERE", "RETURN", "DELETE", "SET", "CREATE", "ORDER", "BY",
    "LIMIT", "AND", "OR", "ASC", "DESC", "true", "false"
  };
  string op_spelling [19] = '{
    "(", ")", "[", "]", "{", "}", ",", ".", ";", ":", "=",
    "!=", ">=", ">", "<-", "<=", "<", "->", "-"
  };

  logic clk;
  logic rst_n;

  qlt_in_if  in_bus ();
  qlt_out_if out_bus ();

  query_language_tokenizer_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Tokens still owed by the block, oldest first, and the failure tally.
  result_t token_q [$];
  int      fail_count = 0;

  // Hold-off requests from the sender; the receiver keeps its own count of those served.
  int      hold_reqs = 0;
  logic    tx_calm   = 1'b0;

  // Append one token to the list of those owed.
  function automatic void owe(input result_t r);
    token_q = {token_q, r};
  endfunction

  // ---------------------------------------------------------------------------------
  // Scanner model. It mirrors the block's state and, for one accepted word, leaves the
  // tokens that word causes in step_res[0 .. step_n-1].
  // ---------------------------------------------------------------------------------
  mode_t   sc_mode;
  logic    sc_dot_held;
  pos_t    sc_pos;
  pos_t    sc_tstart;
  cnt_t    sc_line;
  cnt_t    sc_col;
  cnt_t    sc_tcol;
  byte_t   sc_kw [KW_DEPTH];
  logic    sc_locked;
  result_t step_res [MAX_RES];
  int      step_n;

  function automatic pos_t pos_up(input pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  function automatic cnt_t cnt_up(input cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic is_num(input byte_t c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_letter(input byte_t c);
    return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

  function automatic void scanner_clear();
    sc_mode     = M_IDLE;
    sc_dot_held = 1'b0;
    sc_pos      = '0;
    sc_tstart   = '0;
    sc_line     = cnt_t'(1);
    sc_col      = cnt_t'(1);
    sc_tcol     = cnt_t'(1);
    foreach (sc_kw[i]) sc_kw[i] = '0;
    sc_locked   = 1'b0;
  endfunction

  // Length from the token start to end_pos, held at the counter ceiling.
  function automatic cnt_t lexeme_len(input pos_t end_pos);
    pos_t d;
    d = (end_pos >= sc_tstart) ? end_pos - sc_tstart : '0;
    return (d > CNT_CEIL) ? '1 : cnt_t'(d);
  endfunction

  function automatic void record(input kind_t kind, input err_t err, input pos_t start,
                                 input cnt_t len, input cnt_t col, input logic last);
    result_t r;
    r.kind  = kind;
    r.err   = err;
    r.start = start;
    r.len   = len;
    r.line  = sc_line;
    r.col   = col;
    r.last  = last;
    if (step_n < MAX_RES) begin
      step_res[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic void close_token(input kind_t kind, input pos_t end_pos);
    record(kind, E_NONE, sc_tstart, lexeme_len(end_pos), sc_tcol, 1'b0);
  endfunction

  function automatic void flag_error(input err_t code, input cnt_t len, input cnt_t col);
    record(ERROR_KIND, code, sc_tstart, len, col, 1'b1);
    sc_locked = 1'b1;
  endfunction

  function automatic void step_on();
    sc_pos = pos_up(sc_pos);
    sc_col = cnt_up(sc_col);
  endfunction

  // Identifier or keyword: only an exact match of length and text is a keyword.
  function automatic void close_word();
    cnt_t  n;
    kind_t k;
    logic  hit;
    n = lexeme_len(sc_pos);
    k = K_IDENT;
    if (n >= 1 && n <= KW_DEPTH) begin
      for (int w = 0; w < KW_NUM; w++) begin
        hit = (kw_spelling[w].len() == int'(n));
        for (int i = 0; i < KW_DEPTH; i++)
          if (hit && i < int'(n) && sc_kw[i] != byte_t'(kw_spelling[w][i])) hit = 1'b0;
        if (hit && k == K_IDENT) k = kind_t'(K_KW0 + w);
      end
    end
    close_token(k, sc_pos);
  endfunction

  // The held dot was not followed by a digit: number first, then the dot on its own.
  function automatic void split_number();
    pos_t dot_pos;
    cnt_t dot_col;
    dot_pos = (sc_pos == '0) ? sc_pos : sc_pos - pos_t'(1);
    dot_col = (sc_col == '0) ? sc_col : sc_col - cnt_t'(1);
    close_token(K_NUMBER, dot_pos);
    record(K_DOT, E_NONE, dot_pos, cnt_t'(1), dot_col, 1'b0);
    sc_dot_held = 1'b0;
  endfunction

  // A byte seen between tokens.
  function automatic void scan_fresh(input byte_t c);
    kind_t single;
    logic  is_single;
    sc_tstart = sc_pos;
    sc_tcol   = sc_col;
    single    = K_LPAR;
    is_single = 1'b1;
    case (c)
      CH_LPAR:  single = K_LPAR;
      CH_RPAR:  single = K_RPAR;
      CH_LBRK:  single = K_LBRK;
      CH_RBRK:  single = K_RBRK;
      CH_LBRC:  single = K_LBRC;
      CH_RBRC:  single = K_RBRC;
      CH_COMMA: single = K_COMMA;
      CH_DOT:   single = K_DOT;
      CH_SEMI:  single = K_SEMI;
      CH_COLON: single = K_COLON;
      CH_EQ:    single = K_EQ;
      default:  is_single = 1'b0;
    endcase
    if (is_single) begin
      close_token(single, pos_up(sc_pos));
      step_on();
    end else if (c == CH_BANG) begin
      sc_mode = M_BANG;
      step_on();
    end else if (c == CH_GT) begin
      sc_mode = M_GT;
      step_on();
    end else if (c == CH_LT) begin
      sc_mode = M_LT;
      step_on();
    end else if (c == CH_DASH) begin
      sc_mode = M_DASH;
      step_on();
    end else if (c == CH_QUOTE) begin
      sc_mode = M_STR;
      step_on();
    end else if (c == CH_SP || c == CH_CR || c == CH_TAB) begin
      step_on();
    end else if (c == CH_NL) begin
      sc_pos  = pos_up(sc_pos);
      sc_line = cnt_up(sc_line);
      sc_col  = cnt_t'(1);
    end else if (is_num(c)) begin
      sc_mode     = M_INT;
      sc_dot_held = 1'b0;
      step_on();
    end else if (is_letter(c) || c == CH_UNDER) begin
      foreach (sc_kw[i]) sc_kw[i] = '0;
      sc_kw[0] = c;
      sc_mode  = M_IDENT;
      step_on();
    end else begin
      flag_error(E_UNEXP, cnt_t'(1), cnt_up(sc_col));
    end
  endfunction

  // A byte seen in any mode. Where no token is under way, or the token ends before this
  // byte, the byte is scanned from the idle state.
  function automatic void feed_byte(input byte_t c);
    logic rescan;
    cnt_t n;
    rescan = 1'b0;
    case (sc_mode)
      M_BANG: begin
        if (c == CH_EQ) begin
          close_token(K_NE, pos_up(sc_pos));
          sc_mode = M_IDLE;
          step_on();
        end else begin
          flag_error(E_BANG, cnt_t'(1), sc_col);
        end
      end
      M_GT: begin
        if (c == CH_EQ) begin
          close_token(K_GE, pos_up(sc_pos));
          sc_mode = M_IDLE;
          step_on();
        end else begin
          close_token(K_GT, sc_pos);
          rescan = 1'b1;
        end
      end
      M_LT: begin
        if (c == CH_DASH || c == CH_EQ) begin
          close_token((c == CH_DASH) ? K_LARROW : K_LE, pos_up(sc_pos));
          sc_mode = M_IDLE;
          step_on();
        end else begin
          close_token(K_LT, sc_pos);
          rescan = 1'b1;
        end
      end
      M_DASH: begin
        if (c == CH_GT) begin
          close_token(K_RARROW, pos_up(sc_pos));
          sc_mode = M_IDLE;
          step_on();
        end else begin
          close_token(K_MINUS, sc_pos);
          rescan = 1'b1;
        end
      end
      M_STR: begin
        if (c == CH_QUOTE) begin
          step_on();
          close_token(K_STRING, sc_pos);
          sc_mode = M_IDLE;
        end else begin
          if (c == CH_NL) begin
            sc_line = cnt_up(sc_line);
            sc_col  = cnt_t'(1);
          end
          step_on();
        end
      end
      M_INT: begin
        if (sc_dot_held) begin
          if (is_num(c)) begin
            sc_dot_held = 1'b0;
            sc_mode     = M_FRAC;
            step_on();
          end else begin
            split_number();
            rescan = 1'b1;
          end
        end else if (is_num(c)) begin
          step_on();
        end else if (c == CH_DOT) begin
          sc_dot_held = 1'b1;
          step_on();
        end else begin
          close_token(K_NUMBER, sc_pos);
          rescan = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_num(c)) begin
          step_on();
        end else begin
          close_token(K_NUMBER, sc_pos);
          rescan = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_letter(c) || is_num(c) || c == CH_UNDER) begin
          n = lexeme_len(sc_pos);
          if (n < KW_DEPTH) sc_kw[int'(n)] = c;
          step_on();
        end else begin
          close_word();
          rescan = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase
    if (rescan) begin
      sc_mode = M_IDLE;
      scan_fresh(c);
    end
  endfunction

  // End of source: finish whatever is pending, then END, unless a bang or an open string ends it in an error.
  function automatic void close_source();
    if (sc_mode == M_BANG) begin
      flag_error(E_BANG, cnt_t'(1), sc_col);
    end else if (sc_mode == M_STR) begin
      flag_error(E_UNTERM, lexeme_len(sc_pos), sc_col);
    end else begin
      case (sc_mode)
        M_GT:    close_token(K_GT, sc_pos);
        M_LT:    close_token(K_LT, sc_pos);
        M_DASH:  close_token(K_MINUS, sc_pos);
        M_INT:   if (sc_dot_held) split_number(); else close_token(K_NUMBER, sc_pos);
        M_FRAC:  close_token(K_NUMBER, sc_pos);
        M_IDENT: close_word();
        default: ;
      endcase
      record(K_END, E_NONE, sc_pos, '0, sc_col, 1'b1);
    end
  endfunction

  function automatic void predict_word(input src_word_t w);
    step_n = 0;
    if (w.has_char && !sc_locked) feed_byte(w.ch);
    if (w.is_last) begin
      if (!sc_locked) close_source();
      scanner_clear();
    end
  endfunction

  function automatic void file_step();
    for (int i = 0; i < step_n; i++) owe(step_res[i]);
  endfunction

  // ---------------------------------------------------------------------------------
  // Comparison of one received token with the oldest one owed.
  // ---------------------------------------------------------------------------------
  function automatic void report_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    fail_count++;
  endfunction

  function automatic void check_token(input result_t got);
    result_t want;
    if (token_q.size() == 0) begin
      $display("%0t: token kind %0d at offset %0d, expected none", $time, got.kind, got.start);
      fail_count++;
      return;
    end
    want = token_q.pop_front();
    if (got.kind  != want.kind)  report_field("token_kind", want.kind, got.kind);
    if (got.err   != want.err)   report_field("error_code", want.err, got.err);
    if (got.start != want.start) report_field("start_offset", want.start, got.start);
    if (got.len   != want.len)   report_field("token_length", want.len, got.len);
    if (got.line  != want.line)  report_field("line_number", want.line, got.line);
    if (got.col   != want.col)   report_field("column_number", want.col, got.col);
    if (got.last  != want.last)  report_field("last_of_run", want.last, got.last);
  endfunction

  // ---------------------------------------------------------------------------------
  // Random source text. Most of it is well-formed token sequences with random content,
  // so that every scanning mode is reached; a small share is stray bytes, bare bangs and
  // strings left open, which can end a source in an error.
  // ---------------------------------------------------------------------------------
  src_word_t gen_q [$];
  int        gen_count = 0;

  function automatic void queue_word(input src_word_t w);
    gen_q = {gen_q, w};
  endfunction

  function automatic void add_byte(input byte_t c);
    queue_word('{c, 1'b1, 1'b0});
    gen_count++;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(byte_t'(s[i]));
  endfunction

  function automatic byte_t word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return CH_UA + byte_t'(r);
    if (r < 52) return CH_LA + byte_t'(r - 26);
    if (r < 62) return CH_0 + byte_t'(r - 52);
    return CH_UNDER;
  endfunction

  function automatic byte_t blank_char();
    case ($urandom_range(0, 3))
      0:       return CH_TAB;
      1:       return CH_CR;
      2:       return CH_NL;
      default: return CH_SP;
    endcase
  endfunction

  // Anything may sit inside a string except the closing quote.
  function automatic byte_t string_char();
    byte_t c;
    case ($urandom_range(0, 9))
      0:       c = CH_NL;
      1, 2, 3: c = byte_t'($urandom_range(0, 255));
      default: c = word_char();
    endcase
    return (c == CH_QUOTE) ? CH_SP : c;
  endfunction

  function automatic void gen_source();
    int    ntok;
    int    pick;
    int    len;
    byte_t lead;
    if ($urandom_range(0, 7) == 0) queue_word('{byte_t'($urandom_range(0, 255)), 1'b0, 1'b0});
    ntok = $urandom_range(1, 10);
    for (int t = 0; t < ntok; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        // A keyword, now and then spoilt by a trailing character.
        add_text(kw_spelling[$urandom_range(0, KW_NUM - 1)]);
        if ($urandom_range(0, 3) == 0) add_byte(word_char());
      end else if (pick < 30) begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        lead = word_char();
        add_byte(is_num(lead) ? CH_UNDER : lead);
        repeat (len - 1) add_byte(word_char());
      end else if (pick < 44) begin
        repeat ($urandom_range(1, 4)) add_byte(CH_0 + byte_t'($urandom_range(0, 9)));
        case ($urandom_range(0, 3))
          0: begin
            add_byte(CH_DOT);
            repeat ($urandom_range(1, 3)) add_byte(CH_0 + byte_t'($urandom_range(0, 9)));
          end
          1:       add_byte(CH_DOT);
          default: ;
        endcase
      end else if (pick < 54) begin
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) add_byte(string_char());
        if ($urandom_range(0, 19) != 0) add_byte(CH_QUOTE);
      end else if (pick < 80) begin
        add_text(op_spelling[$urandom_range(0, 18)]);
      end else if (pick < 93) begin
        add_byte(blank_char());
      end else if (pick < 97) begin
        add_byte(byte_t'($urandom_range(0, 255)));
      end else begin
        add_byte(CH_BANG);
      end
      if ($urandom_range(0, 1) == 0) add_byte(blank_char());
    end
    // The source ends either on its last byte or with a word that only marks the end.
    if ($urandom_range(0, 2) != 0) begin
      gen_q[gen_q.size() - 1].is_last = 1'b1;
    end else begin
      queue_word('{byte_t'($urandom_range(0, 255)), 1'b0, 1'b1});
      gen_count++;
    end
  endfunction

  // Sender gap for the next word: random, apart from stretches with no gaps at all.
  function automatic int tx_gap();
    if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
    return tx_calm ? 0 : $urandom_range(0, 14);
  endfunction

  // Present one word, hold it until the block takes it, then let the model see it.
  task automatic offer(input src_word_t w, input int gap);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.ch       <= w.ch;
    in_bus.has_char <= w.has_char;
    in_bus.is_last  <= w.is_last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_word(w);
  endtask

  // Stop offering until every owed token has come back.
  task automatic drain_wait();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------
  // Stimulus: reset, the directed table, then the random sources with one pause and one
  // burst against a held-off receiver. Then the block is drained and the verdict given.
  // ---------------------------------------------------------------------------------
  initial begin : source_feed
    int burst;
    in_bus.valid    <= 1'b0;
    in_bus.ch       <= '0;
    in_bus.has_char <= 1'b0;
    in_bus.is_last  <= 1'b0;
    rst_n           <= 1'b0;
    scanner_clear();
    burst = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows. Typed rows supply their own outcome; the model still steps so that
    // its state follows the block.
    for (int r = 0; r < N_DIRECTED; r++) begin
      offer('{DIRECTED[r].ch, DIRECTED[r].has_char, DIRECTED[r].is_last}, tx_gap());
      if (DIRECTED[r].typed) begin
        if (DIRECTED[r].one_token) owe(DIRECTED[r].token);
      end else begin
        file_step();
      end
    end

    while (gen_count < RANDOM_WORDS) gen_source();
    for (int i = 0; i < gen_q.size(); i++) begin
      // A third of the way in, the sender waits for the block to empty completely.
      if (i == gen_q.size() / 3) drain_wait();
      // Two thirds in, the receiver holds off for a long while and the sender keeps
      // pushing words back to back, so the result queue fills and the input stalls.
      if (i == 2 * gen_q.size() / 3) begin
        hold_reqs++;
        burst = BURST_WORDS;
      end
      offer(gen_q[i], (burst > 0) ? 0 : tx_gap());
      if (burst > 0) burst--;
      file_step();
    end

    in_bus.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Receiver. Every cycle it checks a token taken at this edge and decides ready for
  // the next one: low during a requested hold-off or a random stall drawn after each
  // token, with stretches where it never stalls.
  // ---------------------------------------------------------------------------------
  initial begin : token_sink
    result_t got;
    int      stall_left;
    int      hold_left;
    int      hold_seen;
    logic    rx_calm;
    out_bus.ready <= 1'b0;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    rx_calm    = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        got.kind  = out_bus.token_kind;
        got.err   = out_bus.error_code;
        got.start = out_bus.start_offset;
        got.len   = out_bus.token_length;
        got.line  = out_bus.line_number;
        got.col   = out_bus.column_number;
        got.last  = out_bus.last_of_run;
        check_token(got);
        if ($urandom_range(0, 24) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, 14);
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake or a lost token ends the run here.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: no progress after %0d cycles, %0d tokens still owed",
             $time, CYCLE_LIMIT, token_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
